@@ hw/rtl/sha256_hash_engine_unit_assert.svh @@
// Assertion macros used by the checker module.
`ifndef SHA256_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA256_HASH_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hw/rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;
   localparam int QueueDepth = 4;
   localparam logic [7:0] PadByte = 8'h80;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [31:0] word_type;

   function automatic word_type round_const(input logic [5:0] t);
      word_type k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
   function automatic word_type ssig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction
   function automatic word_type ssig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction
   function automatic word_type bsig0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction
   function automatic word_type bsig1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction
endpackage

@@ hw/rtl/sha_stream_if.sv @@
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface sha_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/sha_queue.sv @@
// ----------------------------------------------------------------------------
// sha_queue
// Short queue of input items between the front and the back part.
// ----------------------------------------------------------------------------
module sha_queue import sha_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);
   localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
   req_type        store_ff [Depth];
   logic [Aw-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [Aw:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == (Aw+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = store_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == Aw'(Depth - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == Aw'(Depth - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) store_ff[wr_ff] <= push_data;
   end
endmodule

@@ hw/rtl/sha_back.sv @@
// ----------------------------------------------------------------------------
// sha_back
// Block assembly, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_back import sha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  req_type q_data,
   output logic    q_pop,
   sha_stream_if.source rsp
);
   typedef enum logic [5:0] {
      ST_TAKE  = 6'b000001,
      ST_ROUND = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];     // block words, then the rolling schedule
   logic [63:0] len_ff;
   logic [5:0]  pos_ff;        // bytes held in the current block
   logic [5:0]  rnd_ff;
   logic        fin_ff;        // a block of only zeros and length follows this one
   logic        last_ff;       // after this compression the digest follows
   logic        pad_ff;        // message ended with the byte that filled a block
   logic [2:0]  out_ff;
   logic        rsp_valid_ff;

   word_type w_new, w_cur, t1, t2;
   logic [1:0] bsel;
   logic       len_here;

   assign w_new = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
   assign w_cur = w_ff[0];
   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + round_const(rnd_ff) + w_cur;
   assign t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));

   assign bsel     = pos_ff[1:0];
   assign len_here = fin_ff || (pos_ff < 6'd56);

   assign q_pop         = (state_ff == ST_TAKE) && !q_empty;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.payload   = '{digest_word: h_ff[out_ff], word_index: out_ff,
                            last_word: (out_ff == 3'd7)};

   // Writes one byte into the word store at the current position.
   function automatic word_type put_byte(input word_type w, input logic [1:0] s,
                                         input logic [7:0] b);
      word_type m;
      m = 32'hff000000 >> {s, 3'b000};
      return (w & ~m) | ({b, 24'h0} >> {s, 3'b000});
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_TAKE: if (!q_empty) begin
            if (q_data.byte_valid && pos_ff == 6'd63) state_in = ST_ROUND;
            else if (q_data.end_of_message) state_in = ST_PAD;
         end
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD:   state_in = last_ff ? ST_EMIT : ((fin_ff || pad_ff) ? ST_PAD : ST_TAKE);
         ST_PAD:   state_in = ST_ROUND;
         ST_EMIT:  if (rsp.ready && out_ff == 3'd7) state_in = ST_FIN;
         ST_FIN:   state_in = ST_TAKE;
         default:  state_in = ST_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         len_ff   <= '0;
         pos_ff   <= '0;
         rnd_ff   <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         pad_ff   <= 1'b0;
         out_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_TAKE: if (!q_empty) begin
               if (q_data.byte_valid) begin
                  w_ff[pos_ff[5:2]] <= put_byte(w_ff[pos_ff[5:2]], bsel, q_data.message_byte);
                  len_ff <= len_ff + 64'd8;
                  pos_ff <= pos_ff + 6'd1;
                  if (pos_ff == 6'd63) begin
                     for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                     rnd_ff <= '0;
                     pad_ff <= q_data.end_of_message;
                  end
               end
            end
            ST_PAD: begin
               // Place 0x80 after the last byte and clear the rest of the
               // block; the length goes into the last two words when it fits.
               // The second of two final blocks holds only zeros and length.
               for (int i = 0; i < 16; i++) begin
                  if (len_here && i == 14) begin
                     w_ff[i] <= len_ff[63:32];
                  end else if (len_here && i == 15) begin
                     w_ff[i] <= len_ff[31:0];
                  end else if (fin_ff) begin
                     w_ff[i] <= '0;
                  end else if (4'(i) == pos_ff[5:2]) begin
                     w_ff[i] <= (w_ff[i] & ~(32'hffffffff >> {bsel, 3'b000}))
                              | ({PadByte, 24'h0} >> {bsel, 3'b000});
                  end else if (4'(i) > pos_ff[5:2]) begin
                     w_ff[i] <= '0;
                  end
               end
               if (fin_ff) begin
                  last_ff <= 1'b1;
                  fin_ff  <= 1'b0;
               end else if (pos_ff < 6'd56) begin
                  last_ff <= 1'b1;
               end else begin
                  fin_ff <= 1'b1;
               end
               pad_ff <= 1'b0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               rnd_ff <= '0;
            end
            ST_ROUND: begin
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_new;
               rnd_ff <= rnd_ff + 6'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               pos_ff <= '0;
               if (last_ff) begin
                  rsp_valid_ff <= 1'b1;
                  out_ff <= '0;
               end
            end
            ST_EMIT: if (rsp.ready) begin
               out_ff <= out_ff + 3'd1;
               if (out_ff == 3'd7) rsp_valid_ff <= 1'b0;
            end
            ST_FIN: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
               len_ff  <= '0;
               pos_ff  <= '0;
               last_ff <= 1'b0;
               fin_ff  <= 1'b0;
               pad_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule

@@ hw/rtl/sha_front.sv @@
// ----------------------------------------------------------------------------
// sha_front
// Accepts items, drops idle items and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
   sha_stream_if.sink req,
   input  logic    q_full,
   output logic    q_push,
   output req_type q_data
);
   assign req.ready = !q_full;
   assign q_data    = req.payload;
   assign q_push    = req.valid && !q_full
                    && (req.payload.byte_valid || req.payload.end_of_message);
endmodule

@@ hw/rtl/sha256_hash_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// SHA-256 engine taking one message byte per item, eight digest words out.
// ----------------------------------------------------------------------------
// A byte item is taken while the queue has room. Every 64th byte starts a
// compression (one round per cycle in the single round unit, then the hash
// update), during which further items only fill the four-entry queue. An end
// item adds one or two padded blocks, then eight result items are shown one
// per cycle as the sink takes them. Items with neither a byte nor the end
// flag are taken and dropped.
module sha256_hash_engine_unit import sha_pkg::*; #(
   parameter int QDepth = QueueDepth
) (
   input logic clock,
   input logic reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   logic    q_full, q_push, q_empty, q_pop;
   req_type q_in, q_out;

   // Front part: accept and classify.
   sha_front u_front (.req(req), .q_full(q_full), .q_push(q_push), .q_data(q_in));

   sha_queue #(.Depth(QDepth)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out)
   );

   // Back part: blocks, rounds and digest.
   sha_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
      .rsp(rsp)
   );
endmodule

@@ hw/rtl/sha_checker.sv @@
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest output sequence.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_unit_assert.svh"
module sha_checker import sha_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   `SHA_ASSERT_IMPL(a_last_idx, clock, reset, rsp_valid, rsp_payload.last_word == (rsp_payload.word_index == 3'd7))
   `SHA_ASSERT_NEXT(a_step, clock, reset, rsp_valid && rsp_ready && !rsp_payload.last_word, rsp_valid && rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1)
   `SHA_ASSERT_NEXT(a_gap, clock, reset, rsp_valid && rsp_ready && rsp_payload.last_word, !rsp_valid)
endmodule

bind sha256_hash_engine_unit sha_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
